### rtl/jsontok_pkg.sv
package jsontok_pkg;

  localparam int MAX_MSG_LEN_DEF = 65536;
  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [2:0] {
    ST_OUT  = 3'd0,
    ST_OBJ  = 3'd1,
    ST_KEY  = 3'd2,
    ST_AKEY = 3'd3,
    ST_VAL  = 3'd4,
    ST_AVAL = 3'd5
  } parse_state_t;

  typedef enum logic [1:0] {
    STAT_RUN = 2'd0,
    STAT_OK  = 2'd1,
    STAT_ERR = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_INCOMPLETE  = 4'd1,
    ERR_BRACE_IN    = 4'd2,
    ERR_QUOTE_AVAL  = 4'd3,
    ERR_QUOTE_OUT   = 4'd4,
    ERR_COLON       = 4'd5,
    ERR_CLOSE_BRACE = 4'd6,
    ERR_INVALID     = 4'd7,
    ERR_NO_BRACE    = 4'd8
  } err_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             key_byte_valid;
    logic             value_byte_valid;
    logic             key_done;
    logic             value_done;
    logic [CNT_W-1:0] string_length;
    logic [CNT_W-1:0] pair_number;
    status_t          status;
    err_t             error_code;
    logic [CNT_W-1:0] error_position;
  } res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

### rtl/jsontok_parser.sv
module jsontok_parser import jsontok_pkg::*; #(
  parameter int MAX_MESSAGE_LEN = MAX_MSG_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output res_t       res
);

  localparam logic [CNT_W-1:0] PosCap = CNT_W'(MAX_MESSAGE_LEN - 1);

  parse_state_t     parse_state, parse_state_next;
  logic [CNT_W-1:0] byte_position, byte_position_next;
  logic [CNT_W-1:0] string_count, string_count_next;
  logic [CNT_W-1:0] pair_count, pair_count_next;
  status_t          message_over, message_over_next;
  err_t             held_error, held_error_next;
  logic [CNT_W-1:0] held_error_position, held_error_position_next;
  logic [CNT_W-1:0] last_nonspace_position, last_nonspace_position_next;
  logic             last_nonspace_was_brace, last_nonspace_was_brace_next;
  logic             seen_nonspace, seen_nonspace_next;

  err_t             err;
  logic             ended_ok, kdone, vdone, str_open, pair_inc;
  logic             running, in_string, str_data, nonspace;
  logic [CNT_W-1:0] err_position;

  assign running   = (message_over == STAT_RUN);
  assign in_string = (parse_state == ST_KEY) || (parse_state == ST_VAL);
  assign nonspace  = (in_byte != CH_SPACE);

  // next state decode
  always_comb begin
    parse_state_next = parse_state;
    err      = ERR_NONE;
    ended_ok = 1'b0;
    kdone    = 1'b0;
    vdone    = 1'b0;
    str_open = 1'b0;
    pair_inc = 1'b0;
    case (in_byte)
      CH_NUL: begin
        if (parse_state == ST_OUT) ended_ok = 1'b1;
        else err = ERR_INCOMPLETE;
      end
      CH_LBRACE: begin
        if (parse_state == ST_OUT) parse_state_next = ST_OBJ;
        else if (parse_state inside {ST_OBJ, ST_AKEY, ST_AVAL}) err = ERR_BRACE_IN;
      end
      CH_QUOTE: begin
        case (parse_state)
          ST_OBJ: begin
            parse_state_next = ST_KEY;
            str_open = 1'b1;
          end
          ST_KEY: begin
            parse_state_next = ST_AKEY;
            kdone = 1'b1;
          end
          ST_AKEY: begin
            parse_state_next = ST_VAL;
            str_open = 1'b1;
          end
          ST_VAL: begin
            parse_state_next = ST_AVAL;
            vdone = 1'b1;
          end
          ST_AVAL: err = ERR_QUOTE_AVAL;
          default: err = ERR_QUOTE_OUT;
        endcase
      end
      CH_COLON: begin
        if (parse_state inside {ST_OBJ, ST_AVAL}) err = ERR_COLON;
      end
      CH_COMMA: begin
        if (parse_state == ST_AVAL) begin
          pair_inc = 1'b1;
          parse_state_next = ST_OBJ;
        end
      end
      CH_RBRACE: begin
        if (parse_state == ST_AVAL) parse_state_next = ST_OUT;
        else if (!in_string) err = ERR_CLOSE_BRACE;
      end
      CH_SPACE: begin
      end
      default: begin
        if (!in_string) err = ERR_INVALID;
      end
    endcase
  end

  assign str_data = (err == ERR_NONE) && in_string && (parse_state_next == parse_state);
  assign err_position = ((in_byte == CH_NUL) && (byte_position != '0)) ?
                        byte_position - 1'b1 : byte_position;

  // counters and message status
  always_comb begin
    byte_position_next           = byte_position;
    string_count_next            = string_count;
    pair_count_next              = pair_count;
    message_over_next            = message_over;
    held_error_next              = held_error;
    held_error_position_next     = held_error_position;
    last_nonspace_position_next  = last_nonspace_position;
    last_nonspace_was_brace_next = last_nonspace_was_brace;
    seen_nonspace_next           = seen_nonspace;
    if (running) begin
      byte_position_next = (byte_position >= PosCap) ? PosCap : byte_position + 1'b1;
      if (str_open) string_count_next = '0;
      else if (str_data) string_count_next = sat_inc(string_count);
      if (pair_inc) pair_count_next = sat_inc(pair_count);
      if (nonspace) begin
        seen_nonspace_next           = 1'b1;
        last_nonspace_position_next  = byte_position;
        last_nonspace_was_brace_next = (in_byte == CH_RBRACE);
      end
      if (err != ERR_NONE) begin
        message_over_next        = STAT_ERR;
        held_error_next          = err;
        held_error_position_next = err_position;
      end else if (ended_ok) begin
        message_over_next = STAT_OK;
      end else if (in_last) begin
        if (!seen_nonspace_next) begin
          message_over_next        = STAT_ERR;
          held_error_next          = ERR_NO_BRACE;
          held_error_position_next = '0;
        end else if (!last_nonspace_was_brace_next) begin
          message_over_next        = STAT_ERR;
          held_error_next          = ERR_NO_BRACE;
          held_error_position_next = last_nonspace_position_next;
        end else begin
          message_over_next = STAT_OK;
        end
      end
    end
  end

  // result outputs
  always_comb begin
    res.data_byte        = in_byte;
    res.key_byte_valid   = running && str_data && (parse_state == ST_KEY);
    res.value_byte_valid = running && str_data && (parse_state == ST_VAL);
    res.key_done         = running && kdone;
    res.value_done       = running && vdone;
    res.string_length    = (running && (kdone || vdone)) ? string_count_next : '0;
    res.pair_number      = pair_count_next;
    res.status           = message_over_next;
    if (message_over_next == STAT_ERR) begin
      res.error_code     = held_error_next;
      res.error_position = held_error_position_next;
    end else begin
      res.error_code     = ERR_NONE;
      res.error_position = '0;
    end
  end

  // a last byte returns everything to the idle message state
  always_ff @(posedge clk) begin
    if (rst || (step && in_last)) begin
      parse_state             <= ST_OUT;
      byte_position           <= '0;
      string_count            <= '0;
      pair_count              <= '0;
      message_over            <= STAT_RUN;
      held_error              <= ERR_NONE;
      held_error_position     <= '0;
      last_nonspace_position  <= '0;
      last_nonspace_was_brace <= 1'b0;
      seen_nonspace           <= 1'b0;
    end else if (step) begin
      if (running) parse_state <= parse_state_next;
      byte_position           <= byte_position_next;
      string_count            <= string_count_next;
      pair_count              <= pair_count_next;
      message_over            <= message_over_next;
      held_error              <= held_error_next;
      held_error_position     <= held_error_position_next;
      last_nonspace_position  <= last_nonspace_position_next;
      last_nonspace_was_brace <= last_nonspace_was_brace_next;
      seen_nonspace           <= seen_nonspace_next;
    end
  end

endmodule

### rtl/flat_json_object_tokenizer.sv
// flat json object tokenizer
// input stream: one message byte per transaction on s_axis_tdata, with
// s_axis_tlast on the final byte of the message.
// output stream: exactly one result transaction per input byte, in order.
// m_axis_tuser flags the byte as key data, value data or a closing quote;
// m_axis_tdata carries the byte, string length on a closing quote, pair
// number, status (running, finished ok, error) and the held error code and
// byte position.
// a result passes through the input register, then the state update into the
// result register, before it is offered.
// throughput: one byte per cycle while the receiver does not stall; the parse
// state update is a single short decode, so bytes flow back to back.
// when the receiver stalls, the result register holds and the input register
// still takes one more byte; s_axis_tready falls once both are full.
// reset clears both registers and returns the parser to the state of a new
// message; every last byte also returns it there.
module flat_json_object_tokenizer import jsontok_pkg::*; #(
  parameter int MAX_MESSAGE_LEN = MAX_MSG_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // data_byte, string_length, pair_number, status, error_code, error_position
  output logic [63:0] m_axis_tdata,
  // key_byte_valid, value_byte_valid, key_done, value_done
  output logic [3:0]  m_axis_tuser
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;
  res_t       res;
  res_t       out_res;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  jsontok_parser #(
    .MAX_MESSAGE_LEN(MAX_MESSAGE_LEN)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .in_byte (in_byte),
    .in_last (in_last),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {2'b00, out_res.error_position, out_res.error_code, out_res.status,
                         out_res.pair_number, out_res.string_length, out_res.data_byte};
  assign m_axis_tuser = {out_res.value_done, out_res.key_done,
                         out_res.value_byte_valid, out_res.key_byte_valid};

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot0(m_axis_tuser))
    else $error("more than one result flag set");

  a_error_code_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((out_res.status == STAT_ERR) == (out_res.error_code != ERR_NONE)))
    else $error("error code disagrees with status");

  a_length_only_on_done: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !out_res.key_done && !out_res.value_done) |->
      (out_res.string_length == '0))
    else $error("string length without closing quote");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_byte) && $stable(in_last)))
    else $error("input register lost a waiting byte");

endmodule
